// ===== hdl/pcf_pkg.sv =====
package pcf_pkg;

    localparam int COLOR_W     = 16;
    localparam int OPAC_W      = 17;
    localparam int MODE_W      = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int NUM_CHAN    = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // channel order inside packed color arrays
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    typedef logic [MODE_W-1:0] mode_t;

    localparam mode_t MODE_FADE   = 3'd0;
    localparam mode_t MODE_RANDOM = 3'd1;
    localparam mode_t MODE_NEGATE = 3'd2;
    localparam mode_t MODE_DODGE  = 3'd3;
    localparam mode_t MODE_BURN   = 3'd4;
    localparam mode_t MODE_TINT   = 3'd5;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_FADE_MODE   = 3'd0;
    localparam cfg_idx_t CFG_FADER_RED   = 3'd1;
    localparam cfg_idx_t CFG_FADER_GREEN = 3'd2;
    localparam cfg_idx_t CFG_FADER_BLUE  = 3'd3;
    localparam cfg_idx_t CFG_OPACITY     = 3'd4;

    localparam logic [COLOR_W-1:0] LFSR_TAPS = 16'hb400;
    localparam logic [COLOR_W-1:0] SEED_INIT = 16'h0001;
    localparam logic [COLOR_W-1:0] HALF_SCALE = 16'h8000;

    typedef logic [NUM_CHAN-1:0][COLOR_W-1:0] color_t;

    // static configuration seen by both front and back
    typedef struct packed {
        mode_t               mode;
        color_t              fader;
        logic [OPAC_W-1:0]   opacity;
    } cfg_t;

    // one classified entry waiting for the back end
    typedef struct packed {
        mode_t  mode;
        color_t entry;
        color_t operand;
        logic   last;
    } job_t;

    function automatic logic [COLOR_W-1:0] lfsr_step(input logic [COLOR_W-1:0] seed);
        logic [COLOR_W-1:0] shifted;
        shifted = seed >> 1;
        return seed[0] ? (shifted ^ LFSR_TAPS) : shifted;
    endfunction

    // smallest all-ones mask covering the opacity pinned to 16 bits
    function automatic logic [COLOR_W-1:0] noise_mask(input logic [OPAC_W-1:0] opac);
        logic [COLOR_W-1:0] m;
        m = opac[OPAC_W-1] ? '1 : opac[COLOR_W-1:0];
        m = m | (m >> 1);
        m = m | (m >> 2);
        m = m | (m >> 4);
        m = m | (m >> 8);
        return m;
    endfunction

endpackage

// ===== hdl/pcf_front.sv =====
module pcf_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  pcf_pkg::cfg_t   cfg,
    input  logic            in_valid,
    output logic            in_ready,
    input  pcf_pkg::color_t entry,
    input  logic            in_last,
    input  logic            q_full,
    output logic            push,
    output pcf_pkg::job_t   push_job
);

    logic [pcf_pkg::COLOR_W-1:0] seed_reg;
    logic [pcf_pkg::COLOR_W-1:0] seed_next;
    logic [pcf_pkg::COLOR_W-1:0] brightest;
    logic [7:0]                  inten;
    logic [pcf_pkg::COLOR_W-1:0] mask;
    logic [pcf_pkg::NUM_CHAN-1:0][pcf_pkg::COLOR_W-1:0] draws;
    logic [pcf_pkg::NUM_CHAN-1:0][pcf_pkg::COLOR_W+7:0] tint_prod;

    assign in_ready = !q_full;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        brightest = (entry[pcf_pkg::CH_RED] >= entry[pcf_pkg::CH_GREEN])
                  ? entry[pcf_pkg::CH_RED] : entry[pcf_pkg::CH_GREEN];
        if (entry[pcf_pkg::CH_BLUE] > brightest)
        begin
            brightest = entry[pcf_pkg::CH_BLUE];
        end
        inten = brightest[pcf_pkg::COLOR_W-1 -: 8];
        mask  = pcf_pkg::noise_mask(cfg.opacity);

        // red, green, blue draw in that order
        draws[pcf_pkg::CH_RED]   = pcf_pkg::lfsr_step(seed_reg);
        draws[pcf_pkg::CH_GREEN] = pcf_pkg::lfsr_step(draws[pcf_pkg::CH_RED]);
        draws[pcf_pkg::CH_BLUE]  = pcf_pkg::lfsr_step(draws[pcf_pkg::CH_GREEN]);

        push_job.mode  = cfg.mode;
        push_job.entry = entry;
        push_job.last  = in_last;
        for (int k = 0; k < pcf_pkg::NUM_CHAN; k++)
        begin
            tint_prod[k] = {8'b0, cfg.fader[k]} * {16'b0, inten};
            unique case (cfg.mode)
                pcf_pkg::MODE_RANDOM: push_job.operand[k] = draws[k] & mask;
                pcf_pkg::MODE_TINT:   push_job.operand[k] = tint_prod[k][pcf_pkg::COLOR_W+7:8];
                default:              push_job.operand[k] = cfg.fader[k];
            endcase
        end

        seed_next = seed_reg;
        if (push && (cfg.mode == pcf_pkg::MODE_RANDOM))
        begin
            seed_next = draws[pcf_pkg::CH_BLUE];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= pcf_pkg::SEED_INIT;
        end
        else
        begin
            seed_reg <= seed_next;
        end
    end

    // a galois lfsr started at one never reaches zero
    a_seed_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        seed_reg != '0)
        else $error("noise seed collapsed to zero");

endmodule

// ===== hdl/pcf_queue.sv =====
module pcf_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  pcf_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output pcf_pkg::job_t head_job
);

    pcf_pkg::job_t               mem_reg [pcf_pkg::QUEUE_DEPTH];
    logic [pcf_pkg::PTR_W-1:0]   wr_ptr_reg;
    logic [pcf_pkg::PTR_W-1:0]   wr_ptr_next;
    logic [pcf_pkg::PTR_W-1:0]   rd_ptr_reg;
    logic [pcf_pkg::PTR_W-1:0]   rd_ptr_next;
    logic [pcf_pkg::CNT_W-1:0]   count_reg;
    logic [pcf_pkg::CNT_W-1:0]   count_next;

    localparam logic [pcf_pkg::PTR_W-1:0] LAST_SLOT = pcf_pkg::PTR_W'(pcf_pkg::QUEUE_DEPTH - 1);
    localparam logic [pcf_pkg::CNT_W-1:0] FULL_CNT  = pcf_pkg::CNT_W'(pcf_pkg::QUEUE_DEPTH);

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_job   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("push into full queue");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not follow push");

endmodule

// ===== hdl/pcf_back.sv =====
module pcf_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  pcf_pkg::cfg_t   cfg,
    input  logic            q_valid,
    input  pcf_pkg::job_t   q_job,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output pcf_pkg::color_t out_color,
    output logic            out_last
);

    logic                    s1_valid_reg;
    pcf_pkg::job_t           job1_reg;
    logic signed [33:0]      prod_reg [pcf_pkg::NUM_CHAN];
    logic signed [33:0]      prod     [pcf_pkg::NUM_CHAN];
    logic signed [16:0]      mul_x    [pcf_pkg::NUM_CHAN];
    logic signed [16:0]      mul_y    [pcf_pkg::NUM_CHAN];
    logic                    out_valid_reg;
    pcf_pkg::color_t         out_color_reg;
    pcf_pkg::color_t         result;
    logic                    out_last_reg;
    logic                    out_load;

    function automatic logic [pcf_pkg::COLOR_W-1:0] lane_result(
        input pcf_pkg::mode_t                 m,
        input logic [pcf_pkg::COLOR_W-1:0]    a,
        input logic [pcf_pkg::COLOR_W-1:0]    d,
        input logic signed [33:0]             p,
        input logic [pcf_pkg::OPAC_W-1:0]     o
    );
        logic signed [18:0]           sa;
        logic signed [18:0]           so;
        logic signed [18:0]           sx;
        logic signed [18:0]           sp;
        logic signed [18:0]           t;
        logic signed [18:0]           v;
        logic [pcf_pkg::COLOR_W-1:0]  res;
        sa  = $signed({3'b0, a});
        so  = $signed({2'b0, o});
        sx  = $signed({3'b0, a ^ d});
        sp  = $signed({3'b0, p[31:16]});
        t   = 19'sd65536 - so;
        v   = '0;
        res = a;
        unique case (m) inside
            pcf_pkg::MODE_FADE, pcf_pkg::MODE_TINT:
            begin
                // floor of product / 256 is an arithmetic shift
                res = a + p[23:8];
            end
            pcf_pkg::MODE_RANDOM:
            begin
                res = a + d;
            end
            pcf_pkg::MODE_NEGATE:
            begin
                if (a > pcf_pkg::HALF_SCALE)
                begin
                    v   = sx + t;
                    res = (v > sa) ? a : v[15:0];
                end
                else
                begin
                    v   = sx - t;
                    res = (v < sa) ? a : v[15:0];
                end
            end
            pcf_pkg::MODE_DODGE:
            begin
                v   = 19'sd65535 - sp - so;
                res = (sa > v) ? v[15:0] : a;
            end
            pcf_pkg::MODE_BURN:
            begin
                v   = sp + 19'sd65536 - so;
                res = ((v >= 0) && (sa > v)) ? v[15:0] : a;
            end
            default:
            begin
                res = a;
            end
        endcase
        return res;
    endfunction

    assign out_load = s1_valid_reg && (!out_valid_reg || out_ready);
    assign pop      = q_valid && (!s1_valid_reg || out_load);

    // operand selection and one multiplier per lane
    always_comb
    begin
        for (int k = 0; k < pcf_pkg::NUM_CHAN; k++)
        begin
            unique case (q_job.mode) inside
                pcf_pkg::MODE_FADE, pcf_pkg::MODE_TINT:
                begin
                    mul_x[k] = $signed({1'b0, q_job.operand[k]}) - $signed({1'b0, q_job.entry[k]});
                    mul_y[k] = $signed({8'b0, cfg.opacity[pcf_pkg::OPAC_W-1:8]});
                end
                pcf_pkg::MODE_DODGE:
                begin
                    mul_x[k] = $signed({1'b0, ~q_job.operand[k]});
                    mul_y[k] = $signed({1'b0, q_job.entry[k]});
                end
                pcf_pkg::MODE_BURN:
                begin
                    mul_x[k] = $signed({1'b0, q_job.operand[k]});
                    mul_y[k] = $signed({1'b0, q_job.entry[k]});
                end
                default:
                begin
                    mul_x[k] = '0;
                    mul_y[k] = '0;
                end
            endcase
            prod[k] = mul_x[k] * mul_y[k];
        end
    end

    always_comb
    begin
        for (int k = 0; k < pcf_pkg::NUM_CHAN; k++)
        begin
            result[k] = lane_result(job1_reg.mode, job1_reg.entry[k], job1_reg.operand[k],
                                    prod_reg[k], cfg.opacity);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (out_load)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job1_reg <= q_job;
            for (int k = 0; k < pcf_pkg::NUM_CHAN; k++)
            begin
                prod_reg[k] <= prod[k];
            end
        end
        if (out_load)
        begin
            out_color_reg <= result;
            out_last_reg  <= job1_reg.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_color = out_color_reg;
    assign out_last  = out_last_reg;

    a_pop_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("pop from empty queue");

    a_stage_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_load) |=> s1_valid_reg)
        else $error("multiply stage dropped an entry");

endmodule

// ===== hdl/palette_color_fader.sv =====
// palette_color_fader: applies the configured fade effect to one rgb palette entry
// path from input transfer to out_valid: queue write, multiply stage, output register
// throughput: one entry per cycle while out_ready is high; a low out_ready stalls the back end
// the two-entry queue lets the front keep accepting while a result waits on out_ready
// reset: async active low, clears config registers to zero, noise seed to one, queue and stages empty
module palette_color_fader
(
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [pcf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pcf_pkg::OPAC_W-1:0]          cfg_wdata,
    // input channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [pcf_pkg::COLOR_W-1:0]         entry_red,
    input  logic [pcf_pkg::COLOR_W-1:0]         entry_green,
    input  logic [pcf_pkg::COLOR_W-1:0]         entry_blue,
    input  logic                                is_last,
    // output channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [pcf_pkg::COLOR_W-1:0]         out_red,
    output logic [pcf_pkg::COLOR_W-1:0]         out_green,
    output logic [pcf_pkg::COLOR_W-1:0]         out_blue,
    output logic                                out_last
);

    // configuration registers
    pcf_pkg::mode_t              fade_mode_reg;
    logic [pcf_pkg::COLOR_W-1:0] fader_red_reg;
    logic [pcf_pkg::COLOR_W-1:0] fader_green_reg;
    logic [pcf_pkg::COLOR_W-1:0] fader_blue_reg;
    logic [pcf_pkg::OPAC_W-1:0]  opacity_reg;

    pcf_pkg::cfg_t   cfg;
    pcf_pkg::color_t entry;
    pcf_pkg::color_t out_color;
    pcf_pkg::job_t   push_job;
    pcf_pkg::job_t   head_job;
    logic            push;
    logic            q_full;
    logic            pop;
    logic            head_valid;

    // writes to unused indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fade_mode_reg   <= pcf_pkg::MODE_FADE;
            fader_red_reg   <= '0;
            fader_green_reg <= '0;
            fader_blue_reg  <= '0;
            opacity_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pcf_pkg::CFG_FADE_MODE:   fade_mode_reg   <= cfg_wdata[pcf_pkg::MODE_W-1:0];
                pcf_pkg::CFG_FADER_RED:   fader_red_reg   <= cfg_wdata[pcf_pkg::COLOR_W-1:0];
                pcf_pkg::CFG_FADER_GREEN: fader_green_reg <= cfg_wdata[pcf_pkg::COLOR_W-1:0];
                pcf_pkg::CFG_FADER_BLUE:  fader_blue_reg  <= cfg_wdata[pcf_pkg::COLOR_W-1:0];
                pcf_pkg::CFG_OPACITY:     opacity_reg     <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        cfg.mode                       = fade_mode_reg;
        cfg.fader[pcf_pkg::CH_RED]     = fader_red_reg;
        cfg.fader[pcf_pkg::CH_GREEN]   = fader_green_reg;
        cfg.fader[pcf_pkg::CH_BLUE]    = fader_blue_reg;
        cfg.opacity                    = opacity_reg;
        entry[pcf_pkg::CH_RED]         = entry_red;
        entry[pcf_pkg::CH_GREEN]       = entry_green;
        entry[pcf_pkg::CH_BLUE]        = entry_blue;
    end

    // front: accepts the transfer, advances the noise seed in random mode, prepares the blend operand
    pcf_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .entry    (entry),
        .in_last  (is_last),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    // short queue decoupling front and back
    pcf_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // back: multiply stage, then clamp or blend into the output register
    pcf_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (head_valid),
        .q_job     (head_job),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_color (out_color),
        .out_last  (out_last)
    );

    assign out_red   = out_color[pcf_pkg::CH_RED];
    assign out_green = out_color[pcf_pkg::CH_GREEN];
    assign out_blue  = out_color[pcf_pkg::CH_BLUE];

endmodule
